// ===== rtl/core/csf_pkg.sv =====
// Shared types and constants of the conjugate-symmetry fill addresser.
package csf_pkg;

    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 17;
    localparam int CFG_DIMS = 3;
    localparam int MASK_W   = 3;
    localparam int INDEX_W  = 4;

    localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

    typedef enum logic [INDEX_W-1:0] {
        REG_SIZE_DIM0       = 4'd0,
        REG_SIZE_DIM1       = 4'd1,
        REG_SIZE_DIM2       = 4'd2,
        REG_MIRROR_MASK     = 4'd3,
        REG_OUT_STRIDE_DIM0 = 4'd4,
        REG_OUT_STRIDE_DIM1 = 4'd5,
        REG_OUT_STRIDE_DIM2 = 4'd6,
        REG_OUT_BASE        = 4'd7
    } t_reg_index;

    typedef struct packed {
        logic [CFG_DIMS-1:0][SIZE_W-1:0] size;
        logic [MASK_W-1:0]               mirror;
        logic [CFG_DIMS-1:0][DATA_W-1:0] stride;
        logic [DATA_W-1:0]               base;
    } t_cfg;

endpackage

// ===== rtl/core/csf_cfg_regs.sv =====
// Configuration register file of the conjugate-symmetry fill addresser.
module csf_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [csf_pkg::INDEX_W-1:0]          i_cfg_index,
    input  logic [csf_pkg::DATA_W-1:0]           i_cfg_data,
    output csf_pkg::t_cfg                        o_cfg
);

    csf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size      <= {csf_pkg::CFG_DIMS{csf_pkg::SIZE_W'(1)}};
            r_cfg.mirror    <= '0;
            // stride of dimension 0 resets to one, the others to zero
            r_cfg.stride    <= {{((csf_pkg::CFG_DIMS-1)*csf_pkg::DATA_W){1'b0}},
                                csf_pkg::DATA_W'(1)};
            r_cfg.base      <= '0;
        end else if (i_cfg_valid) begin
            case (csf_pkg::t_reg_index'(i_cfg_index))
                csf_pkg::REG_SIZE_DIM0:       r_cfg.size[0]   <= i_cfg_data[csf_pkg::SIZE_W-1:0];
                csf_pkg::REG_SIZE_DIM1:       r_cfg.size[1]   <= i_cfg_data[csf_pkg::SIZE_W-1:0];
                csf_pkg::REG_SIZE_DIM2:       r_cfg.size[2]   <= i_cfg_data[csf_pkg::SIZE_W-1:0];
                csf_pkg::REG_MIRROR_MASK:     r_cfg.mirror    <= i_cfg_data[csf_pkg::MASK_W-1:0];
                csf_pkg::REG_OUT_STRIDE_DIM0: r_cfg.stride[0] <= i_cfg_data;
                csf_pkg::REG_OUT_STRIDE_DIM1: r_cfg.stride[1] <= i_cfg_data;
                csf_pkg::REG_OUT_STRIDE_DIM2: r_cfg.stride[2] <= i_cfg_data;
                csf_pkg::REG_OUT_BASE:        r_cfg.base      <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/csf_coord_stage.sv =====
// Coordinate counter, mirror mapping and conjugation; first pipeline stage.
module csf_coord_stage #(
    parameter int MAX_DIMS   = 3,
    parameter int COORD_BITS = 16,
    parameter int NMUL       = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  csf_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [csf_pkg::DATA_W-1:0]            i_real,
    input  logic [csf_pkg::DATA_W-1:0]            i_imag,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [NMUL-1:0][csf_pkg::DATA_W-1:0]  o_map,
    output logic [csf_pkg::DATA_W-1:0]            o_real,
    output logic [csf_pkg::DATA_W-1:0]            o_imag,
    output logic                                  o_last
);

    // Width holding an effective size up to 2^COORD_BITS and the raw 17-bit register.
    localparam int CW = (COORD_BITS + 1 > csf_pkg::SIZE_W) ? COORD_BITS + 1 : csf_pkg::SIZE_W;
    // Width for the mirrored difference, wrapping modulo 2^32.
    localparam int MW = (CW > csf_pkg::DATA_W) ? CW : csf_pkg::DATA_W;
    localparam logic [CW-1:0] LIMIT = CW'(1) << COORD_BITS;

    logic [MAX_DIMS-1:0][COORD_BITS-1:0] r_coord;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] n_coord;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] w_inc;
    logic [MAX_DIMS-1:0]                 w_lt;
    logic [MAX_DIMS:0]                   w_carry;
    logic [NMUL-1:0][csf_pkg::DATA_W-1:0] w_map;

    logic [NMUL-1:0][csf_pkg::DATA_W-1:0] r_map;
    logic [csf_pkg::DATA_W-1:0]           r_real;
    logic [csf_pkg::DATA_W-1:0]           r_imag;
    logic                                 r_last;
    logic                                 r_valid;
    logic                                 w_accept;

    genvar d;
    generate
        for (d = 0; d < MAX_DIMS; d++) begin : g_dim
            logic [CW-1:0] w_eff;
            logic [CW-1:0] w_k1;
            if (d < csf_pkg::CFG_DIMS) begin : g_cfg
                logic [CW-1:0] w_raw;
                assign w_raw = CW'(i_cfg.size[d]);
                // zero acts as one, saturate at the counter range
                assign w_eff = (w_raw == '0) ? CW'(1) :
                               (w_raw > LIMIT) ? LIMIT : w_raw;
            end else begin : g_fix
                assign w_eff = CW'(1);
            end
            assign w_k1     = CW'(r_coord[d]) + CW'(1);
            assign w_lt[d]  = (w_k1 < w_eff);
            assign w_inc[d] = w_k1[COORD_BITS-1:0];
            if (d < NMUL) begin : g_map
                logic [MW-1:0] w_diff;
                logic [MW-1:0] w_k;
                assign w_k    = MW'(r_coord[d]);
                assign w_diff = MW'(w_eff) - w_k;
                assign w_map[d] = (i_cfg.mirror[d] && (r_coord[d] != '0)) ?
                                  w_diff[csf_pkg::DATA_W-1:0] : w_k[csf_pkg::DATA_W-1:0];
            end
        end
    endgenerate

    // Advance dimension 0 and ripple the wrap upward.
    always_comb begin
        w_carry[0] = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++) begin
            w_carry[i+1] = w_carry[i] && !w_lt[i];
            if (w_carry[i]) begin
                n_coord[i] = w_lt[i] ? w_inc[i] : '0;
            end else begin
                n_coord[i] = r_coord[i];
            end
        end
    end

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_accept) begin
                r_coord <= n_coord;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_map  <= w_map;
            r_real <= i_real;
            r_imag <= i_imag ^ csf_pkg::SIGN_BIT;
            r_last <= w_carry[MAX_DIMS];
        end
    end

    assign o_valid = r_valid;
    assign o_map   = r_map;
    assign o_real  = r_real;
    assign o_imag  = r_imag;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/csf_addr_stage.sv =====
// Stride products and address sum; second and third pipeline stages.
module csf_addr_stage #(
    parameter int NMUL = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  csf_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [NMUL-1:0][csf_pkg::DATA_W-1:0]  i_map,
    input  logic [csf_pkg::DATA_W-1:0]            i_real,
    input  logic [csf_pkg::DATA_W-1:0]            i_imag,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [csf_pkg::DATA_W-1:0]            o_addr,
    output logic [csf_pkg::DATA_W-1:0]            o_real,
    output logic [csf_pkg::DATA_W-1:0]            o_imag,
    output logic                                  o_last
);

    logic [NMUL-1:0][csf_pkg::DATA_W-1:0] r_prod;
    logic [NMUL-1:0][csf_pkg::DATA_W-1:0] w_prod;
    logic [csf_pkg::DATA_W-1:0]           r_real2;
    logic [csf_pkg::DATA_W-1:0]           r_imag2;
    logic                                 r_last2;
    logic                                 r_valid2;
    logic                                 w_ready2;

    logic [csf_pkg::DATA_W-1:0]           r_addr;
    logic [csf_pkg::DATA_W-1:0]           n_addr;
    logic [csf_pkg::DATA_W-1:0]           r_real3;
    logic [csf_pkg::DATA_W-1:0]           r_imag3;
    logic                                 r_last3;
    logic                                 r_valid3;
    logic                                 w_ready3;

    genvar j;
    generate
        for (j = 0; j < NMUL; j++) begin : g_mul
            // keep the low word of the product: address wraps modulo 2^32
            assign w_prod[j] = i_cfg.stride[j] * i_map[j];
        end
    endgenerate

    always_comb begin
        n_addr = i_cfg.base;
        for (int i = 0; i < NMUL; i++) begin
            n_addr = n_addr + r_prod[i];
        end
    end

    assign w_ready3 = !r_valid3 || i_ready;
    assign w_ready2 = !r_valid2 || w_ready3;
    assign o_ready  = w_ready2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (w_ready2) begin
                r_valid2 <= i_valid;
            end
            if (w_ready3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2 && i_valid) begin
            r_prod  <= w_prod;
            r_real2 <= i_real;
            r_imag2 <= i_imag;
            r_last2 <= i_last;
        end
        if (w_ready3 && r_valid2) begin
            r_addr  <= n_addr;
            r_real3 <= r_real2;
            r_imag3 <= r_imag2;
            r_last3 <= r_last2;
        end
    end

    assign o_valid = r_valid3;
    assign o_addr  = r_addr;
    assign o_real  = r_real3;
    assign o_imag  = r_imag3;
    assign o_last  = r_last3;

endmodule

// ===== rtl/core/conjugate_symmetry_fill_addresser.sv =====
// Top level of the conjugate-symmetry fill addresser.
//
// Takes half-spectrum complex elements in logical order (dimension 0 fastest),
// returns each conjugated value with its output element address
// base + sum(stride[d] * m[d]) mod 2^32, where m[d] is size[d]-k for a mirrored
// dimension with k != 0 and k otherwise; tlast marks the element closing the
// region, after which the counter restarts at zero. One element is accepted
// every cycle while the output is not stalled; each passes three register
// stages (counter and mirror mapping, stride multiplies, then the address
// sum). A stalled output holds the pipeline and drops tready on the input.
// Size 0 acts as 1, sizes above 2^COORD_BITS saturate. Write configuration
// only while the pipeline is empty.
module conjugate_symmetry_fill_addresser #(
    parameter int MAX_DIMS   = 3,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // value_real [31:0], value_imag [63:32]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // out_address [31:0], conj_real [63:32], conj_imag [95:64]
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NMUL = (MAX_DIMS < csf_pkg::CFG_DIMS) ? MAX_DIMS : csf_pkg::CFG_DIMS;

    csf_pkg::t_cfg                        w_cfg;
    logic                                 w_valid1;
    logic                                 w_ready1;
    logic [NMUL-1:0][csf_pkg::DATA_W-1:0] w_map;
    logic [csf_pkg::DATA_W-1:0]           w_real1;
    logic [csf_pkg::DATA_W-1:0]           w_imag1;
    logic                                 w_last1;
    logic [csf_pkg::DATA_W-1:0]           w_addr;
    logic [csf_pkg::DATA_W-1:0]           w_real3;
    logic [csf_pkg::DATA_W-1:0]           w_imag3;

    assign o_cfg_ready = 1'b1;

    csf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    csf_coord_stage #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS),
        .NMUL       (NMUL)
    ) u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_real  (s_axis_tdata[31:0]),
        .i_imag  (s_axis_tdata[63:32]),
        .o_valid (w_valid1),
        .i_ready (w_ready1),
        .o_map   (w_map),
        .o_real  (w_real1),
        .o_imag  (w_imag1),
        .o_last  (w_last1)
    );

    csf_addr_stage #(
        .NMUL (NMUL)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_valid1),
        .o_ready (w_ready1),
        .i_map   (w_map),
        .i_real  (w_real1),
        .i_imag  (w_imag1),
        .i_last  (w_last1),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_addr  (w_addr),
        .o_real  (w_real3),
        .o_imag  (w_imag3),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_imag3, w_real3, w_addr};

endmodule
